FILE: design/kepler_equation_solver_top_assert.svh
// Assertion macros for the Kepler solver top level.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef KEPLER_EQUATION_SOLVER_TOP_ASSERT_SVH
`define KEPLER_EQUATION_SOLVER_TOP_ASSERT_SVH

// Same-cycle implication.
`define KES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/kes_pkg.sv
package kes_pkg;

  localparam int unsigned ANGLE_BITS    = 32;
  localparam int unsigned CORDIC_STAGES = 30;
  localparam int unsigned DIV_STEPS     = 64;
  localparam int unsigned SQRT_STEPS    = 32;
  localparam int unsigned ITERATION_CAP = 15;

  localparam logic [ANGLE_BITS-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ANGLE_BITS-1:0] STEP_LIMIT   = 32'h7FFF_FFFF;
  localparam logic [31:0]           ECC_START_LIMIT = 32'd3435973837;
  localparam logic [31:0]           INV2PI_Q32   = 32'h28BE_60DC;
  localparam logic [63:0]           INV2PI_Q64   = 64'h28BE_60DB_9391_054A;
  localparam logic signed [35:0]    CORDIC_GAIN  = 36'sd652032874;

  // configuration register indexes
  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_MAX_ITER  = 1'b1;

  typedef logic [CORDIC_STAGES-1:0][ANGLE_BITS-1:0] atan_tab_t;

  // atan(2^-i) in turns, from the arctangent series on 1/(2*pi)
  function automatic atan_tab_t build_atan_tab();
    atan_tab_t   tab;
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned i;
    int unsigned k;
    int unsigned sh;
    tab    = '0;
    tab[0] = 32'h2000_0000;
    for (i = 1; i < CORDIC_STAGES; i++) begin
      acc = '0;
      for (k = 0; k < 32; k++) begin
        sh = i * (2 * k + 1);
        if (sh < 64) begin
          term = (INV2PI_Q64 >> sh) / 64'(2 * k + 1);
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
      end
      tab[i] = 32'((acc + 64'h8000_0000) >> 32);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROT_INIT,
    OP_ROT,
    OP_ROT_DONE,
    OP_MUL_ES,
    OP_MUL_EC,
    OP_MUL_INV,
    OP_RESID,
    OP_DIV_INIT,
    OP_DIV,
    OP_STEP,
    OP_SQ_MUL,
    OP_SQ_INIT,
    OP_SQRT,
    OP_R_MUL,
    OP_XY,
    OP_VEC_INIT,
    OP_VEC,
    OP_OUT
  } kes_op_e;

  typedef struct packed {
    kes_op_e    op;
    logic [5:0] idx;
  } kes_cmd_t;

  typedef struct packed {
    logic conv;
  } kes_sts_t;

endpackage

FILE: design/kepler_equation_solver_top.sv
// Channel  Direction  Handshake                      Payload
// s_axis   in         s_axis_tvalid/s_axis_tready    mean anomaly, eccentricity
// m_axis   out        m_axis_tvalid/m_axis_tready    E, true anomaly, passes, flag
// cfg      in         cfg_valid_i/cfg_ready_o        register index, write data
//
// An item makes P Newton passes, P from 1 to 31.
// Each pass runs the 30-step CORDIC rotation and the 64-step restoring divider;
// the closing sqrt (32 steps) and atan2 vectoring (30 steps) follow the last pass.
// A new item is taken only while the controller sits idle; the output register
// holds one finished result, so the next item may run while it waits.
// Reset clears control state and loads tolerance = 1, max_iterations = 15.
module kepler_equation_solver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] mean_angle, [63:32] eccentricity
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] eccentric_anomaly, [63:32] true_anomaly, [68:64] passes_used, [71:69] zero
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tuser,  // [0] not_converged
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import kes_pkg::*;

  logic [7:0]  tol_q;
  logic [4:0]  maxit_q;
  logic [4:0]  cap_eff;
  kes_cmd_t    cmd;
  kes_sts_t    sts;
  logic [31:0] ea_out, ta_out;
  logic [4:0]  passes_out;
  logic        nc_out;

  // register writes are taken at once
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= 8'd1;
      maxit_q <= 5'(ITERATION_CAP);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TOLERANCE: tol_q   <= cfg_data_i;
        CFG_MAX_ITER:  maxit_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // a zero limit still allows one pass
  assign cap_eff = (maxit_q == 5'd0) ? 5'd1 : maxit_q;

  kes_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .passes_used_o   (passes_out),
    .not_converged_o (nc_out),
    .cap_i           (cap_eff),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  kes_dpath u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .tolerance_i         (tol_q),
    .mean_angle_i        (s_axis_tdata[31:0]),
    .eccentricity_i      (s_axis_tdata[63:32]),
    .sts_o               (sts),
    .eccentric_anomaly_o (ea_out),
    .true_anomaly_o      (ta_out)
  );

  assign m_axis_tdata = {3'b000, passes_out, ta_out, ea_out};
  assign m_axis_tuser = nc_out;

`include "kepler_equation_solver_top_assert.svh"

  `KES_ASSERT_NOW(a_flag_at_cap, m_axis_tvalid && m_axis_tuser, passes_out == cap_eff, "flag set below cap")
  `KES_ASSERT_NOW(a_passes_range, m_axis_tvalid, (passes_out != 5'd0) && (passes_out <= cap_eff), "passes out of range")
  `KES_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after transfer")

endmodule

FILE: design/kes_dpath.sv
module kes_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kes_pkg::kes_cmd_t cmd_i,
  input  logic [7:0]        tolerance_i,
  input  logic [31:0]       mean_angle_i,
  input  logic [31:0]       eccentricity_i,
  output kes_pkg::kes_sts_t sts_o,
  output logic [31:0]       eccentric_anomaly_o,
  output logic [31:0]       true_anomaly_o
);
  import kes_pkg::*;

  logic [31:0]        m_q, e_q, ea_q;
  logic signed [35:0] cx_q, cy_q;
  logic signed [33:0] cz_q;
  logic               rneg_q;
  logic signed [35:0] c_q;
  logic [31:0]        sm_q, cm_q;
  logic               s_neg_q;
  logic [63:0]        prod_q;
  logic [33:0]        tr_q, ec_q;
  logic signed [34:0] f_q;
  logic [34:0]        d_q;
  logic [33:0]        fm_q;
  logic               conv_q;
  logic [35:0]        rem_q;
  logic [31:0]        quo_q;
  logic               ovf_q;
  logic [63:0]        sv_q, sres_q;
  logic               zero_q;
  logic [31:0]        eo_q, to_q;

  logic [4:0]         i;
  logic signed [35:0] xs, ys;
  logic signed [33:0] at;
  logic               dplus;
  logic signed [33:0] z0;
  logic [31:0]        t32;
  logic signed [34:0] diff, tsg, f_new;
  logic [34:0]        d_new;
  logic [33:0]        fm_new;
  logic               bit_in;
  logic [35:0]        rs;
  logic [5:0]         sh;
  logic [63:0]        bitv, tv;
  logic [32:0]        r;
  logic [31:0]        ym, tstep;
  logic signed [35:0] ysg;
  logic [30:0]        e4;

  assign i     = cmd_i.idx[4:0];
  assign xs    = cx_q >>> i;
  assign ys    = cy_q >>> i;
  assign at    = (32'(i) < CORDIC_STAGES) ? signed'({2'b00, ATAN_TAB[i]}) : '0;
  assign dplus = (cmd_i.op == OP_ROT) ? !cz_q[33] : (cy_q <= 36'sd0);

  assign z0 = 34'(signed'(ea_q));

  assign t32   = 32'((prod_q + 64'h8000_0000) >> 32);
  assign diff  = 35'(signed'(ea_q - m_q));
  assign tsg   = signed'({3'b000, t32});
  assign f_new = diff - (s_neg_q ? -tsg : tsg);

  always_comb begin
    if (!c_q[35]) begin
      d_new = (ec_q < 34'h1_0000_0000) ? 35'h1_0000_0000 - 35'(ec_q) : 35'd1;
    end else begin
      d_new = 35'h1_0000_0000 + 35'(ec_q);
    end
  end

  assign fm_new = f_q[34] ? 34'(-f_q) : 34'(f_q);

  // numerator bits come from the low word of |f|, zeros afterwards
  assign bit_in = !cmd_i.idx[5] && fm_q[~i];
  assign rs     = {rem_q[34:0], bit_in};

  assign sh   = 6'd62 - {i, 1'b0};
  assign bitv = 64'd1 << sh;
  assign tv   = sres_q + bitv;

  assign r     = (e_q == 32'd0) ? 33'h1_0000_0000 : sres_q[32:0];
  assign ym    = 32'((prod_q + 64'h8000_0000) >> 32);
  assign ysg   = signed'({4'b0000, ym});
  assign e4    = 31'((33'(e_q) + 33'd2) >> 2);
  assign tstep = (ovf_q || quo_q[31]) ? STEP_LIMIT : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= 1'b0;
    end else if (cmd_i.op == OP_DIV_INIT) begin
      conv_q <= fm_new <= {26'b0, tolerance_i};
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        m_q  <= mean_angle_i;
        e_q  <= eccentricity_i;
        ea_q <= (eccentricity_i < ECC_START_LIMIT) ? mean_angle_i : HALF_TURN;
      end
      OP_ROT_INIT: begin
        cx_q <= CORDIC_GAIN;
        cy_q <= '0;
        // fold into the right half plane
        if (z0 > 34'sd1073741824) begin
          cz_q   <= z0 - 34'sd2147483648;
          rneg_q <= 1'b1;
        end else if (z0 < -34'sd1073741824) begin
          cz_q   <= z0 + 34'sd2147483648;
          rneg_q <= 1'b1;
        end else begin
          cz_q   <= z0;
          rneg_q <= 1'b0;
        end
      end
      OP_ROT, OP_VEC: begin
        if (dplus) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - at;
        end else begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + at;
        end
      end
      OP_ROT_DONE: begin
        c_q     <= rneg_q ? -cx_q : cx_q;
        s_neg_q <= rneg_q ? (cy_q > 36'sd0) : cy_q[35];
        sm_q    <= cy_q[35] ? 32'(-cy_q) : 32'(cy_q);
        cm_q    <= cx_q[35] ? 32'(-cx_q) : 32'(cx_q);
      end
      OP_MUL_ES: prod_q <= 64'(e_q) * 64'(sm_q);
      OP_MUL_EC: begin
        tr_q   <= 34'((prod_q + 64'h2000_0000) >> 30);
        prod_q <= 64'(e_q) * 64'(cm_q);
      end
      OP_MUL_INV: begin
        ec_q   <= 34'((prod_q + 64'h2000_0000) >> 30);
        prod_q <= 64'(tr_q) * 64'(INV2PI_Q32);
      end
      OP_RESID: begin
        f_q <= f_new;
        d_q <= d_new;
      end
      OP_DIV_INIT: begin
        fm_q  <= fm_new;
        rem_q <= '0;
        quo_q <= '0;
        ovf_q <= 1'b0;
      end
      OP_DIV: begin
        if (rs >= {1'b0, d_q}) begin
          rem_q <= rs - {1'b0, d_q};
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= rs;
          quo_q <= {quo_q[30:0], 1'b0};
        end
        ovf_q <= ovf_q | quo_q[31];
      end
      OP_STEP: ea_q <= f_q[34] ? ea_q + tstep : ea_q - tstep;
      OP_SQ_MUL: prod_q <= 64'(e_q) * 64'(e_q);
      OP_SQ_INIT: begin
        sv_q   <= 64'd0 - prod_q;
        sres_q <= '0;
      end
      OP_SQRT: begin
        if (sv_q >= tv) begin
          sv_q   <= sv_q - tv;
          sres_q <= (sres_q >> 1) + bitv;
        end else begin
          sres_q <= sres_q >> 1;
        end
      end
      OP_R_MUL: prod_q <= 64'(r) * 64'(sm_q);
      OP_XY: begin
        cy_q <= s_neg_q ? -ysg : ysg;
        cx_q <= c_q - signed'({5'b00000, e4});
      end
      OP_VEC_INIT: begin
        zero_q <= (cx_q == 36'sd0) && (cy_q == 36'sd0);
        if (cx_q[35]) begin
          cx_q <= -cx_q;
          cy_q <= -cy_q;
          cz_q <= 34'sd2147483648;
        end else begin
          cz_q <= '0;
        end
      end
      OP_OUT: begin
        eo_q <= ea_q;
        to_q <= zero_q ? 32'd0 : cz_q[31:0];
      end
      default: ;
    endcase
  end

  assign sts_o.conv          = conv_q;
  assign eccentric_anomaly_o = eo_q;
  assign true_anomaly_o      = to_q;

endmodule

FILE: design/kes_ctrl.sv
module kes_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [4:0]        passes_used_o,
  output logic              not_converged_o,
  input  logic [4:0]        cap_i,
  input  kes_pkg::kes_sts_t sts_i,
  output kes_pkg::kes_cmd_t cmd_o
);
  import kes_pkg::*;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_ROT_INIT = 5'd1;
  localparam logic [4:0] ST_ROT      = 5'd2;
  localparam logic [4:0] ST_ROT_DONE = 5'd3;
  localparam logic [4:0] ST_MUL_ES   = 5'd4;
  localparam logic [4:0] ST_MUL_EC   = 5'd5;
  localparam logic [4:0] ST_MUL_INV  = 5'd6;
  localparam logic [4:0] ST_RESID    = 5'd7;
  localparam logic [4:0] ST_DIV_INIT = 5'd8;
  localparam logic [4:0] ST_DIV      = 5'd9;
  localparam logic [4:0] ST_STEP     = 5'd10;
  localparam logic [4:0] ST_SQ_MUL   = 5'd11;
  localparam logic [4:0] ST_SQ_INIT  = 5'd12;
  localparam logic [4:0] ST_SQRT     = 5'd13;
  localparam logic [4:0] ST_R_MUL    = 5'd14;
  localparam logic [4:0] ST_XY       = 5'd15;
  localparam logic [4:0] ST_VEC_INIT = 5'd16;
  localparam logic [4:0] ST_VEC      = 5'd17;
  localparam logic [4:0] ST_OUT      = 5'd18;

  localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_STAGES - 1);
  localparam logic [5:0] DIV_LAST    = 6'(DIV_STEPS - 1);
  localparam logic [5:0] SQRT_LAST   = 6'(SQRT_STEPS - 1);

  logic [4:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [4:0] passes_q, passes_d;
  logic       fin_q, fin_d;
  logic       nc_q, nc_d;
  logic       ovld_q, ovld_d;
  logic [4:0] opass_q, opass_d;
  logic       onc_q, onc_d;
  logic [4:0] pnext;

  assign pnext = passes_q + 5'd1;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    passes_d   = passes_q;
    fin_d      = fin_q;
    nc_d       = nc_q;
    ovld_d     = ovld_q && !out_ready_i;
    opass_d    = opass_q;
    onc_d      = onc_q;
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          passes_d = '0;
          fin_d    = 1'b0;
          nc_d     = 1'b0;
          state_d  = ST_ROT_INIT;
        end
      end
      ST_ROT_INIT: begin
        cmd_o.op = OP_ROT_INIT;
        cnt_d    = '0;
        state_d  = ST_ROT;
      end
      ST_ROT: begin
        cmd_o.op = OP_ROT;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == CORDIC_LAST) state_d = ST_ROT_DONE;
      end
      ST_ROT_DONE: begin
        cmd_o.op = OP_ROT_DONE;
        state_d  = fin_q ? ST_SQ_MUL : ST_MUL_ES;
      end
      ST_MUL_ES: begin
        cmd_o.op = OP_MUL_ES;
        state_d  = ST_MUL_EC;
      end
      ST_MUL_EC: begin
        cmd_o.op = OP_MUL_EC;
        state_d  = ST_MUL_INV;
      end
      ST_MUL_INV: begin
        cmd_o.op = OP_MUL_INV;
        state_d  = ST_RESID;
      end
      ST_RESID: begin
        cmd_o.op = OP_RESID;
        state_d  = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == DIV_LAST) state_d = ST_STEP;
      end
      ST_STEP: begin
        // convergence wins over the pass limit
        cmd_o.op = OP_STEP;
        passes_d = pnext;
        state_d  = ST_ROT_INIT;
        if (sts_i.conv) begin
          fin_d = 1'b1;
        end else if (pnext >= cap_i) begin
          fin_d = 1'b1;
          nc_d  = 1'b1;
        end
      end
      ST_SQ_MUL: begin
        cmd_o.op = OP_SQ_MUL;
        state_d  = ST_SQ_INIT;
      end
      ST_SQ_INIT: begin
        cmd_o.op = OP_SQ_INIT;
        cnt_d    = '0;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == SQRT_LAST) state_d = ST_R_MUL;
      end
      ST_R_MUL: begin
        cmd_o.op = OP_R_MUL;
        state_d  = ST_XY;
      end
      ST_XY: begin
        cmd_o.op = OP_XY;
        state_d  = ST_VEC_INIT;
      end
      ST_VEC_INIT: begin
        cmd_o.op = OP_VEC_INIT;
        cnt_d    = '0;
        state_d  = ST_VEC;
      end
      ST_VEC: begin
        cmd_o.op = OP_VEC;
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == CORDIC_LAST) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          ovld_d   = 1'b1;
          opass_d  = passes_q;
          onc_d    = nc_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      passes_q <= '0;
      fin_q    <= 1'b0;
      nc_q     <= 1'b0;
      ovld_q   <= 1'b0;
      opass_q  <= '0;
      onc_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      passes_q <= passes_d;
      fin_q    <= fin_d;
      nc_q     <= nc_d;
      ovld_q   <= ovld_d;
      opass_q  <= opass_d;
      onc_q    <= onc_d;
    end
  end

  assign out_valid_o     = ovld_q;
  assign passes_used_o   = opass_q;
  assign not_converged_o = onc_q;

endmodule

FILE: tb/kepler_equation_solver_top_tb.sv
`timescale 1ns / 100ps

module kepler_equation_solver_top_tb;
  import kes_pkg::*;

  localparam int unsigned  NUM_STAGES  = 30;
  localparam longint       GAIN_Q30    = 652032874;
  localparam logic [63:0]  INV_2PI_Q64 = 64'h28BE_60DB_9391_054A;
  localparam logic [63:0]  INV_2PI_Q32 = 64'h28BE_60DC;
  localparam logic [63:0]  ECC_SWITCH  = 64'd3435973837;
  localparam logic [63:0]  ONE_Q32     = 64'h1_0000_0000;
  localparam logic [63:0]  TURN_MASK   = 64'hFFFF_FFFF;
  localparam logic [63:0]  HALF        = 64'h8000_0000;
  localparam longint       QUARTER     = 64'sh4000_0000;
  localparam logic [63:0]  STEP_SAT    = 64'h7FFF_FFFF;
  localparam int unsigned  DRAIN_CYCLES = 400;
  localparam longint       CYCLE_LIMIT  = 64'd8_000_000;

  typedef struct packed {
    logic [31:0] ea_turn;
    logic [31:0] true_anom;
    logic [4:0]  passes;
    logic        not_conv;
  } solution_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;

  kepler_equation_solver_top u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // predictor state: its own copy of the registers
  logic [7:0]  tol_reg;
  logic [4:0]  iter_cap_reg;
  logic [63:0] atan_turns [NUM_STAGES];

  solution_t   pending_solutions [$];
  int          error_count;
  int          items_sent;
  int          solutions_seen;
  int          unconverged_seen;
  longint      cycle_count;
  bit          quiet_mode;  // drop all random idling on both sides

  function automatic void build_atan_turns();
    logic [63:0] acc;
    logic [63:0] term;
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (i == 0) begin
        atan_turns[0] = 64'h2000_0000;
      end else begin
        acc = '0;
        for (int k = 0; i * (2 * k + 1) < 64; k++) begin
          term = (INV_2PI_Q64 >> (i * (2 * k + 1))) / 64'(2 * k + 1);
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
        atan_turns[i] = (acc + 64'h8000_0000) >> 32;
      end
    end
  endfunction

  function automatic longint wrap_signed(logic [63:0] a);
    logic [63:0] m;
    m = a & TURN_MASK;
    return (m & HALF) != 0 ? longint'(m) - longint'(ONE_Q32) : longint'(m);
  endfunction

  function automatic logic [63:0] rnd_shift(logic [63:0] v, int n);
    return (v + (64'd1 << (n - 1))) >> n;
  endfunction

  task automatic rotate_angle(input logic [63:0] ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit     flip;
    z = wrap_signed(ang);
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (z > QUARTER) begin
      z = z - longint'(HALF); flip = 1'b1;
    end else if (z < -QUARTER) begin
      z = z + longint'(HALF); flip = 1'b1;
    end
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - longint'(atan_turns[i]);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + longint'(atan_turns[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [63:0] vector_angle(longint y, longint x);
    logic [63:0] z;
    longint      nx;
    if (x == 0 && y == 0) return '0;
    z = '0;
    if (x < 0) begin
      x = -x; y = -y; z = HALF;
    end
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_turns[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_turns[i];
      end
      x = nx;
    end
    return z & TURN_MASK;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b); res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // floor(num * 2^32 / d), saturating just under half a turn
  function automatic logic [63:0] newton_step(logic [63:0] num, logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int pos = 63; pos >= 0; pos--) begin
      rem = (rem << 1) | (pos >= 32 ? (num >> (pos - 32)) & 64'd1 : 64'd0);
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d; q = q | 64'd1;
      end
      if (q > STEP_SAT) return STEP_SAT;
    end
    return q;
  endfunction

  task automatic solve_kepler(input logic [31:0] mean_in, input logic [31:0] ecc_in,
                              output solution_t sol);
    logic [63:0] m, e, ea, t, sm, cm, ec, d, fm, r, ym;
    longint      c, s, f, y, x;
    int unsigned cap, passes;
    bit          nc;
    m = 64'(mean_in);
    e = 64'(ecc_in);
    cap = iter_cap_reg == 0 ? 1 : iter_cap_reg;
    passes = 0;
    nc = 1'b0;
    ea = e < ECC_SWITCH ? m : HALF;
    forever begin
      rotate_angle(ea, c, s);
      sm = 64'(s < 0 ? -s : s);
      cm = 64'(c < 0 ? -c : c);
      t = rnd_shift(rnd_shift(e * sm, 30) * INV_2PI_Q32, 32);
      f = wrap_signed(ea - m) - (s < 0 ? -longint'(t) : longint'(t));
      ec = rnd_shift(e * cm, 30);
      if (c >= 0) d = ONE_Q32 > ec ? ONE_Q32 - ec : 64'd1;
      else d = ONE_Q32 + ec;
      fm = 64'(f < 0 ? -f : f);
      t = newton_step(fm, d);
      ea = (f < 0 ? ea + t : ea - t) & TURN_MASK;
      passes++;
      if (fm <= 64'(tol_reg)) break;
      if (passes >= cap) begin
        nc = 1'b1;
        break;
      end
    end
    rotate_angle(ea, c, s);
    sm = 64'(s < 0 ? -s : s);
    r = e == 0 ? ONE_Q32 : floor_sqrt(64'd0 - e * e);
    ym = rnd_shift(r * sm, 32);
    y = s < 0 ? -longint'(ym) : longint'(ym);
    x = c - longint'((e + 64'd2) >> 2);
    sol.ea_turn   = ea[31:0];
    sol.true_anom = 32'(vector_angle(y, x));
    sol.passes    = passes[4:0];
    sol.not_conv  = nc;
  endtask

  // ---------------------------------------------------------------- drivers

  function automatic bit idle_now();
    return !quiet_mode && ($urandom_range(99) < 10);
  endfunction

  // Send one orbit; hold tvalid high on return so back-to-back items stay gapless.
  task automatic send_orbit(input logic [31:0] mean_in, input logic [31:0] ecc_in);
    solution_t sol;
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    solve_kepler(mean_in, ecc_in, sol);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ecc_in, mean_in};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_solutions.push_back(sol);
    items_sent++;
  endtask

  task automatic drop_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    drop_input();
    while (pending_solutions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TOLERANCE) tol_reg = value;
    else iter_cap_reg = value[4:0];
    @(posedge clk_i);
  endtask

  task automatic set_solver(input logic [7:0] tol, input logic [4:0] cap);
    wait_drained();
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_MAX_ITER, {3'b000, cap});
  endtask

  // mix of eccentricities: circular-ish, full range, moderate, around the start switch, near one
  function automatic logic [31:0] random_ecc();
    case ($urandom_range(5))
      0: return $urandom_range(32'h4000_0000);
      1: return $urandom;
      2: return 32'(ECC_SWITCH) + $urandom_range(64) - 32;
      3: return 32'hF000_0000 | $urandom_range(32'h0FFF_FFFF);
      default: return $urandom_range(32'hC000_0000);
    endcase
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    solution_t want;
    if (rst_ni && !quiet_mode) m_axis_tready <= ($urandom_range(99) >= 10);
    else if (rst_ni) m_axis_tready <= 1'b1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      solutions_seen++;
      if (m_axis_tuser) unconverged_seen++;
      if (pending_solutions.size() == 0) begin
        $error("result with no pending expectation: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_solutions.pop_front();
        if (m_axis_tdata[31:0] !== want.ea_turn) begin
          $error("eccentric_anomaly exp %h got %h", want.ea_turn, m_axis_tdata[31:0]);
          error_count++;
        end
        if (m_axis_tdata[63:32] !== want.true_anom) begin
          $error("true_anomaly exp %h got %h", want.true_anom, m_axis_tdata[63:32]);
          error_count++;
        end
        if (m_axis_tdata[68:64] !== want.passes) begin
          $error("passes_used exp %0d got %0d", want.passes, m_axis_tdata[68:64]);
          error_count++;
        end
        if (m_axis_tdata[71:69] !== 3'b000) begin
          $error("pad exp 0 got %b", m_axis_tdata[71:69]);
          error_count++;
        end
        if (m_axis_tuser !== want.not_conv) begin
          $error("not_converged exp %b got %b", want.not_conv, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_orbit(32'h0000_0000, 32'h0000_0000);
    send_orbit(32'hFFFF_FFFF, 32'h0000_0000);
    send_orbit(32'h4000_0000, 32'h0000_0000);
    send_orbit(32'h1234_5678, 32'h8000_0000);
    send_orbit(32'h2000_0000, 32'(ECC_SWITCH) - 1);
    send_orbit(32'h2000_0000, 32'(ECC_SWITCH));
    send_orbit(32'h0000_0001, 32'hFFFF_FFFF);   // near-parabolic: tiny derivative
    send_orbit(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_orbit(32'h8000_0000, 32'hFFFF_FFFF);
    send_orbit(32'h0000_0100, 32'hFFFF_FF00);   // huge first step
    send_orbit(32'h8000_0000, 32'h0000_0000);
    send_orbit(32'hC000_0000, 32'h4000_0000);
    send_orbit(32'h4000_0000, 32'h4000_0000);   // vector in the left half plane
    send_orbit(32'h5555_5555, 32'hAAAA_AAAA);
    send_orbit(32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_config_extremes();
    set_solver(8'd0, 5'd0);                     // zero cap behaves as one pass
    send_orbit(32'h1000_0000, 32'h8000_0000);
    send_orbit(32'h0000_0000, 32'h0000_0000);
    set_solver(8'd255, 5'd1);
    send_orbit(32'h1000_0000, 32'h8000_0000);
    send_orbit(32'hF000_0000, 32'hF000_0000);
    set_solver(8'd0, 5'd31);                    // tight bound, long cap
    send_orbit(32'h0100_0000, 32'hFFFF_FFFF);
    send_orbit(32'h7FFF_FFFF, 32'hE000_0000);
    set_solver(8'd1, 5'd2);                     // converging on the last pass
    send_orbit(32'h2000_0000, 32'h0100_0000);
    send_orbit(32'h2000_0000, 32'h2000_0000);
  endtask

  task automatic test_random_phase(input int count, input logic [7:0] tol,
                                   input logic [4:0] cap);
    set_solver(tol, cap);
    for (int n = 0; n < count; n++) begin
      quiet_mode = (n >= count / 2) && (n < count / 2 + count / 5);
      send_orbit($urandom, random_ecc());
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_pause_until_drained();
    set_solver(8'd4, 5'd15);
    for (int n = 0; n < 12; n++) begin
      send_orbit($urandom, random_ecc());
      if (n == 5) wait_drained();
    end
  endtask

  initial begin
    error_count = 0;
    items_sent = 0;
    solutions_seen = 0;
    unconverged_seen = 0;
    cycle_count = 0;
    quiet_mode = 1'b0;
    tol_reg = 8'd1;
    iter_cap_reg = 5'd15;
    build_atan_turns();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_extremes();
    test_random_phase(200, 8'd1, 5'd15);
    test_random_phase(150, 8'($urandom_range(255)), 5'($urandom_range(1, 8)));
    test_random_phase(100, 8'd0, 5'd4);
    test_random_phase(60, 8'd255, 5'd31);
    test_random_phase(80, 8'($urandom_range(255)), 5'($urandom_range(31)));
    test_pause_until_drained();

    wait_drained();
    $display("Solved %0d orbits, %0d results checked, %0d hit the iteration cap.",
             items_sent, solutions_seen, unconverged_seen);
    $display("Covered tolerance 0..255, caps 0..31, eccentricity 0 to near one.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
